// File: rtl/tmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_pkg: shared types and constants
// Opcodes, memory sizing and the controller to datapath signal groups.
// ----------------------------------------------------------------------------
package tmm_pkg;

  // word count of the data memory, a power of two
  localparam int RAM_WORDS = 1024;
  localparam int ADDR_W    = $clog2(RAM_WORDS);
  localparam int DATA_W    = 32;
  localparam int IN_ADDR_W = 10;

  typedef enum logic [2:0] {
    OP_HALT  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_STORE = 3'd3,
    OP_LOAD  = 3'd4,
    OP_IMM   = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  typedef struct packed {
    logic              load_instr;
    logic              rd_a;
    logic              rd_b;
    logic              commit;
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // addresses wrap modulo the memory size
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [IN_ADDR_W-1:0] a);
    logic [31:0] t;
    t = 32'(a);
    return t[ADDR_W-1:0];
  endfunction

endpackage

// File: rtl/tmm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_ram: generic single-port ram
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module tmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/tmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_ctrl: instruction sequencer
// Runs the memory clear after reset and steps each instruction through its
// read and commit cycles.
// ----------------------------------------------------------------------------
module tmm_ctrl import tmm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_FIN
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(RAM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            unique case (op_t'(op))
              OP_ADD, OP_SUB: state <= S_RD_A;
              OP_LOAD:        state <= S_RD_B;
              default:        state <= S_FIN;
            endcase
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: state <= S_FIN;
        S_FIN: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.load_instr = (state == S_IDLE) && in_valid;
    cmd.rd_a       = (state == S_RD_A);
    cmd.rd_b       = (state == S_RD_B);
    cmd.commit     = (state == S_FIN) && status.out_free;
    cmd.clear      = (state == S_CLEAR);
    cmd.clear_addr = clr_cnt;
  end

endmodule

// File: rtl/tmm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_dp: machine datapath
// Instruction register, the two machine registers, the data memory and the
// result register.
// ----------------------------------------------------------------------------
module tmm_dp import tmm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic [2:0]              op,
  input  logic                    reg_sel,
  input  logic [IN_ADDR_W-1:0]    addr_a,
  input  logic [IN_ADDR_W-1:0]    addr_b,
  input  logic [IN_ADDR_W-1:0]    addr_dest,
  input  logic signed [DATA_W-1:0] immediate,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DATA_W-1:0] result_value,
  output logic                    halted
);

  op_t               i_op;
  logic              i_sel;
  logic [ADDR_W-1:0] i_a;
  logic [ADDR_W-1:0] i_b;
  logic [ADDR_W-1:0] i_d;
  logic [DATA_W-1:0] i_imm;

  logic [DATA_W-1:0] reg_one;
  logic [DATA_W-1:0] reg_two;

  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic              is_arith;
  logic [DATA_W-1:0] arith;
  logic [DATA_W-1:0] sel_reg;
  logic [DATA_W-1:0] value;
  logic              halt_flag;

  assign is_arith = (i_op == OP_ADD) || (i_op == OP_SUB);
  assign arith    = (i_op == OP_SUB) ? reg_one - ram_rdata : reg_one + ram_rdata;
  assign sel_reg  = i_sel ? reg_two : reg_one;

  always_comb begin
    value     = '0;
    halt_flag = 1'b0;
    unique case (i_op)
      OP_HALT:          halt_flag = 1'b1;
      OP_ADD, OP_SUB:   value = arith;
      OP_STORE:         value = sel_reg;
      OP_LOAD:          value = ram_rdata;
      OP_IMM:           value = i_imm;
      OP_READ:          value = sel_reg;
      default:          value = '0;
    endcase
  end

  always_comb begin
    ram_en    = cmd.clear || cmd.rd_a || cmd.rd_b;
    ram_we    = cmd.clear;
    ram_addr  = cmd.clear_addr;
    ram_wdata = '0;
    if (cmd.rd_a) begin
      ram_addr = i_a;
    end else if (cmd.rd_b) begin
      ram_addr = i_b;
    end else if (cmd.commit && is_arith) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = i_d;
      ram_wdata = arith;
    end else if (cmd.commit && (i_op == OP_STORE)) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = i_b;
      ram_wdata = sel_reg;
    end
  end

  tmm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RAM_WORDS)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // instruction register
  always_ff @(posedge clk) begin
    if (cmd.load_instr) begin
      i_op  <= op_t'(op);
      i_sel <= reg_sel;
      i_a   <= wrap_addr(addr_a);
      i_b   <= wrap_addr(addr_b);
      i_d   <= wrap_addr(addr_dest);
      i_imm <= immediate;
    end
  end

  // machine registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_one <= '0;
      reg_two <= '0;
    end else begin
      if (cmd.rd_b && is_arith) begin
        reg_one <= ram_rdata;
      end
      if (cmd.commit) begin
        if (is_arith) begin
          reg_one <= arith;
          reg_two <= ram_rdata;
        end else if ((i_op == OP_LOAD) || (i_op == OP_IMM)) begin
          if (i_sel) begin
            reg_two <= value;
          end else begin
            reg_one <= value;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_value <= value;
      halted       <= halt_flag;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

// File: rtl/two_register_memory_machine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_register_memory_machine_unit: two-register memory-to-memory machine
// Executes one instruction per input beat against a word memory and two
// 32-bit registers and returns one result beat per instruction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  op reg_sel addr_a addr_b addr_dest immediate
//  out      output     out_valid / out_stall result_value halted
//
// steps: add and subtract go through accept, read a, read b and commit; load
// skips read a, other ops skip both; the single memory port splits the reads.
// reset: a clearing pass writes zero to every memory word in turn,
// with in_stall high until it ends.
// stalls: a result beat waits in the output register; an instruction that
// finishes while it is still held waits at its commit cycle.
module two_register_memory_machine_unit import tmm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               op,
  input  logic                     reg_sel,
  input  logic [IN_ADDR_W-1:0]     addr_a,
  input  logic [IN_ADDR_W-1:0]     addr_b,
  input  logic [IN_ADDR_W-1:0]     addr_dest,
  input  logic signed [DATA_W-1:0] immediate,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     halted
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tmm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op      (op),
    .status  (status),
    .cmd     (cmd)
  );

  tmm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .op          (op),
    .reg_sel     (reg_sel),
    .addr_a      (addr_a),
    .addr_b      (addr_b),
    .addr_dest   (addr_dest),
    .immediate   (immediate),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_value(result_value),
    .halted      (halted)
  );

endmodule

// File: verif/tb_two_register_memory_machine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_register_memory_machine_unit: instruction-level check of the machine
// Sends a short table of fixed instructions (extremes, wraparound, aliased
// addresses, halt, unused opcode), then random instruction streams. Every
// instruction is run on a local copy of the memory and both registers, and
// each result beat is compared field by field in order. Both channels idle
// at random, and the sender drains the machine once mid-run.
// ----------------------------------------------------------------------------
module tb_two_register_memory_machine_unit;
  import tmm_pkg::*;

  localparam logic [2:0] OP_UNUSED      = 3'd7;
  localparam int         NUM_DIRECTED   = 24;
  localparam int         NUM_RANDOM     = 1600;
  localparam int         DRAIN_AT       = 800;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         TAIL_CYCLES    = 24;
  localparam logic [31:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN  = 32'h8000_0000;
  localparam logic [31:0] W_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic        sel;
    logic [9:0]  a;
    logic [9:0]  b;
    logic [9:0]  d;
    logic [31:0] imm;
    logic        typed;
    logic [31:0] value;
    logic        halt;
  } instr_row_t;

  typedef struct packed {
    logic [31:0] value;
    logic        halt;
  } beat_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               op = OP_HALT;
  logic                     reg_sel = 1'b0;
  logic [IN_ADDR_W-1:0]     addr_a = '0;
  logic [IN_ADDR_W-1:0]     addr_b = '0;
  logic [IN_ADDR_W-1:0]     addr_dest = '0;
  logic signed [DATA_W-1:0] immediate = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic                     halted;

  logic [31:0]  mem_model [RAM_WORDS];
  logic [31:0]  r1_model;
  logic [31:0]  r2_model;
  beat_result_t pending_results [$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           hold_left = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  instr_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_READ,   1'b0, 10'd0,    10'd0,    10'd0,    32'd0,  1'b1, 32'd0,  1'b0},
    '{OP_READ,   1'b1, 10'd0,    10'd0,    10'd0,    32'd0,  1'b1, 32'd0,  1'b0},
    '{OP_HALT,   1'b1, 10'd7,    10'd9,    10'd11,   W_ONES, 1'b1, 32'd0,  1'b1},
    '{OP_UNUSED, 1'b1, 10'd1023, 10'd1023, 10'd1023, W_MAX,  1'b1, 32'd0,  1'b0},
    '{OP_LOAD,   1'b0, 10'd0,    10'd1023, 10'd0,    32'd0,  1'b1, 32'd0,  1'b0},
    '{OP_IMM,    1'b0, 10'd0,    10'd0,    10'd0,    W_MAX,  1'b1, W_MAX,  1'b0},
    '{OP_IMM,    1'b1, 10'd0,    10'd0,    10'd0,    W_MIN,  1'b1, W_MIN,  1'b0},
    '{OP_STORE,  1'b0, 10'd0,    10'd1023, 10'd0,    32'd0,  1'b1, W_MAX,  1'b0},
    '{OP_STORE,  1'b1, 10'd0,    10'd0,    10'd0,    32'd0,  1'b1, W_MIN,  1'b0},
    '{OP_ADD,    1'b0, 10'd1023, 10'd0,    10'd5,    32'd0,  1'b1, W_ONES, 1'b0},
    '{OP_IMM,    1'b0, 10'd0,    10'd0,    10'd0,    32'd1,  1'b1, 32'd1,  1'b0},
    '{OP_STORE,  1'b0, 10'd0,    10'd1,    10'd0,    32'd0,  1'b1, 32'd1,  1'b0},
    '{OP_ADD,    1'b0, 10'd1023, 10'd1,    10'd2,    32'd0,  1'b1, W_MIN,  1'b0},
    '{OP_SUB,    1'b0, 10'd0,    10'd1,    10'd3,    32'd0,  1'b1, W_MAX,  1'b0},
    '{OP_SUB,    1'b0, 10'd5,    10'd5,    10'd5,    32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_ADD,    1'b0, 10'd2,    10'd2,    10'd2,    32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_READ,   1'b0, 10'd0,    10'd0,    10'd0,    32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_READ,   1'b1, 10'd0,    10'd0,    10'd0,    32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_LOAD,   1'b1, 10'd0,    10'd3,    10'd0,    32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_ADD,    1'b0, 10'd1023, 10'd1023, 10'd1023, 32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_IMM,    1'b1, 10'd0,    10'd0,    10'd0,    W_ONES, 1'b1, W_ONES, 1'b0},
    '{OP_STORE,  1'b1, 10'd0,    10'd1022, 10'd0,    32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_LOAD,   1'b0, 10'd0,    10'd0,    10'd0,    32'd0,  1'b0, 32'd0,  1'b0},
    '{OP_HALT,   1'b0, 10'd0,    10'd0,    10'd0,    32'd0,  1'b1, 32'd0,  1'b1}
  };

  two_register_memory_machine_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .reg_sel      (reg_sel),
    .addr_a       (addr_a),
    .addr_b       (addr_b),
    .addr_dest    (addr_dest),
    .immediate    (immediate),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .halted       (halted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // runs one instruction on the local machine copy
  function automatic beat_result_t machine_execute(input instr_row_t ins);
    beat_result_t res;
    int           ia;
    int           ib;
    int           id;
    ia = int'(ins.a) % RAM_WORDS;
    ib = int'(ins.b) % RAM_WORDS;
    id = int'(ins.d) % RAM_WORDS;
    res = '0;
    case (ins.op)
      OP_HALT: res.halt = 1'b1;
      OP_ADD, OP_SUB: begin
        r1_model = mem_model[ia];
        r2_model = mem_model[ib];
        if (ins.op == OP_ADD) r1_model = r1_model + r2_model;
        else r1_model = r1_model - r2_model;
        mem_model[id] = r1_model;
        res.value = r1_model;
      end
      OP_STORE: begin
        res.value = ins.sel ? r2_model : r1_model;
        mem_model[ib] = res.value;
      end
      OP_LOAD: begin
        res.value = mem_model[ib];
        if (ins.sel) r2_model = res.value;
        else r1_model = res.value;
      end
      OP_IMM: begin
        res.value = ins.imm;
        if (ins.sel) r2_model = res.value;
        else r1_model = res.value;
      end
      OP_READ: res.value = ins.sel ? r2_model : r1_model;
      default: res = '0;
    endcase
    return res;
  endfunction

  // mostly a small hot set so loads and sums see earlier writes
  function automatic logic [9:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 10'($urandom_range(0, 15));
    if (r < 70) return 10'(1023 - $urandom_range(0, 7));
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic instr_row_t random_instr();
    instr_row_t ins;
    int         r;
    ins = '0;
    r = $urandom_range(0, 99);
    if (r < 4) ins.op = OP_HALT;
    else if (r < 26) ins.op = OP_ADD;
    else if (r < 44) ins.op = OP_SUB;
    else if (r < 58) ins.op = OP_STORE;
    else if (r < 70) ins.op = OP_LOAD;
    else if (r < 84) ins.op = OP_IMM;
    else if (r < 96) ins.op = OP_READ;
    else ins.op = OP_UNUSED;
    ins.sel = 1'($urandom_range(0, 1));
    ins.a = pick_addr();
    ins.b = pick_addr();
    ins.d = pick_addr();
    r = $urandom_range(0, 99);
    if (r < 3) ins.imm = W_MAX;
    else if (r < 6) ins.imm = W_MIN;
    else if (r < 9) ins.imm = W_ONES;
    else if (r < 12) ins.imm = 32'd0;
    else if (r < 50) ins.imm = 32'($urandom_range(0, 200)) - 32'd100;
    else ins.imm = $urandom;
    return ins;
  endfunction

  task automatic send_instr(input instr_row_t ins);
    int           gap;
    beat_result_t predicted;
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= ins.op;
    reg_sel   <= ins.sel;
    addr_a    <= ins.a;
    addr_b    <= ins.b;
    addr_dest <= ins.d;
    immediate <= ins.imm;
    do @(posedge clk); while (in_stall);
    predicted = machine_execute(ins);
    if (ins.typed) pending_results.push_back('{ins.value, ins.halt});
    else pending_results.push_back(predicted);
  endtask

  initial begin
    for (int i = 0; i < RAM_WORDS; i++) mem_model[i] = '0;
    r1_model = '0;
    r2_model = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) send_instr(directed_rows[i]);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_instr(random_instr());
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: check each beat, then hold off a random number of cycles
  always @(posedge clk) begin
    beat_result_t want;
    int           hold;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: value %h halted %b", $time,
                 result_value, halted);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value) begin
          errors++;
          $display("%0t: result_value mismatch: expected %h actual %h", $time,
                   want.value, result_value);
        end
        if (halted !== want.halt) begin
          errors++;
          $display("%0t: halted mismatch: expected %b actual %b", $time,
                   want.halt, halted);
        end
      end
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      hold = recv_burst ? 0 : $urandom_range(0, 7);
      hold_left <= hold;
      out_stall <= (hold != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
